@@ design/assert_macros.svh @@
// Assertion macros used by the back end (ldq_back) of the displacement dequantizer RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ldq_pkg.sv @@
// Shared types and constants of the level-of-detail displacement dequantizer.
// No dependencies; every other design file but assert_macros.svh imports this package.
package ldq_pkg;

	localparam int NUM_COMP         = 3;
	localparam int SAMPLE_BITS      = 16;
	localparam int DIFF_BITS        = SAMPLE_BITS + 1;
	localparam int DISP_BITS        = 48;
	localparam int SCALE_BITS       = 32;
	localparam int SCALE_FRAC_BITS  = 24;
	localparam int OUT_FRAC_BITS    = 16;
	localparam int FACTOR_BITS      = 16;
	localparam int FACTOR_FRAC_BITS = 14;
	localparam int END_BITS         = 16;
	localparam int END_SLOTS        = 4;
	localparam int MAX_LEVELS       = 4;
	localparam int LEVEL_CAP        = (MAX_LEVELS < END_SLOTS) ? MAX_LEVELS : END_SLOTS;
	localparam int LEVEL_BITS       = 3;
	localparam int QP_BITS          = 7;
	localparam int DEPTH_BITS       = 5;
	localparam int QUEUE_DEPTH      = 2;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_POS_DEPTH,
		REG_SAMPLE_DEPTH,
		REG_QP_FIRST,
		REG_QP_SECOND,
		REG_QP_THIRD,
		REG_LEVEL_FACTORS,
		REG_LEVEL_ENDS,
		REG_LEVEL_COUNT
	} reg_idx_t;

	// Configuration register file as seen by the datapath.
	typedef struct packed {
		logic [DEPTH_BITS-1:0]                 pos_depth;
		logic [DEPTH_BITS-1:0]                 sample_depth;
		logic [NUM_COMP-1:0][QP_BITS-1:0]      qp;
		logic [NUM_COMP-1:0][FACTOR_BITS-1:0]  level_factors;
		logic [END_SLOTS-1:0][END_BITS-1:0]    level_ends;
		logic [LEVEL_BITS-1:0]                 level_count;
	} cfg_t;

	// One classified vertex as it travels through the queue.
	typedef struct packed {
		logic [NUM_COMP-1:0][DIFF_BITS-1:0] diff;
		logic                               frame_start;
	} item_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_WALK,
		BK_STEP,
		BK_MUL,
		BK_DONE
	} back_state_t;

endpackage

@@ design/ldq_front.sv @@
// Front end: accepts vertex transfers, removes the mid-level offset and queues them.
// Depends on ldq_pkg.
module ldq_front
	import ldq_pkg::*;
(
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample_a,
	input  logic [SAMPLE_BITS-1:0] sample_b,
	input  logic [SAMPLE_BITS-1:0] sample_c,
	input  logic                   frame_start,
	input  logic [DEPTH_BITS-1:0]  sample_depth,
	input  logic                   q_full,
	output logic                   push,
	output item_t                  item
);

	logic [DEPTH_BITS-1:0] depth_clamped;
	logic [DIFF_BITS-1:0]  offset;

	// The offset is half the sample range; a depth of zero gives no offset.
	always_comb begin
		depth_clamped = (sample_depth > DEPTH_BITS'(SAMPLE_BITS)) ?
			DEPTH_BITS'(SAMPLE_BITS) : sample_depth;
		if (depth_clamped == '0) begin
			offset = '0;
		end else begin
			offset = DIFF_BITS'(1) << (depth_clamped - DEPTH_BITS'(1));
		end
	end

	// Differences are signed and one bit wider than the samples.
	always_comb begin
		item.diff[0]     = {1'b0, sample_a} - offset;
		item.diff[1]     = {1'b0, sample_b} - offset;
		item.diff[2]     = {1'b0, sample_c} - offset;
		item.frame_start = frame_start;
	end

	// A transfer is taken whenever the queue has room.
	assign sample_stall = q_full;
	assign push         = sample_valid && !q_full;

endmodule

@@ design/ldq_queue.sv @@
// Short register queue that decouples the front end from the back end.
// Depends on ldq_pkg for house conventions only.
module ldq_queue
	import ldq_pkg::*;
#(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Entry storage carries payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

@@ design/ldq_back.sv @@
// Back end: sequences frame loads, level steps and the displacement multiply.
// Depends on ldq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ldq_back
	import ldq_pkg::*;
#(
	parameter int VERTEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        q_empty,
	input  item_t                       q_data,
	output logic                        pop,
	output logic                        disp_valid,
	input  logic                        disp_stall,
	output logic signed [DISP_BITS-1:0] disp_a,
	output logic signed [DISP_BITS-1:0] disp_b,
	output logic signed [DISP_BITS-1:0] disp_c,
	output logic [15:0]                 vertex_number,
	output logic [1:0]                  level_number,
	output logic                        beyond_levels
);

	localparam int SHIFT     = SCALE_FRAC_BITS - OUT_FRAC_BITS;
	localparam int FPROD_W   = SCALE_BITS + FACTOR_BITS;
	localparam int MPROD_W   = DIFF_BITS + SCALE_BITS + 1;
	localparam int SLOT_BITS = $clog2(END_SLOTS);

	// 2^(r/6) in unsigned Q.32.
	function automatic logic [32:0] root_sixth(input logic [2:0] r);
		case (r)
			3'd0:    root_sixth = 33'd4294967296;
			3'd1:    root_sixth = 33'd4820937788;
			3'd2:    root_sixth = 33'd5411319705;
			3'd3:    root_sixth = 33'd6074001000;
			3'd4:    root_sixth = 33'd6817835604;
			3'd5:    root_sixth = 33'd7652761717;
			default: root_sixth = 33'd4294967296;
		endcase
	endfunction

	// Frame-start scale 2^(p-16+q) * 2^(r/6) with qp-4 = 6q + r, in Q8.24.
	function automatic logic [SCALE_BITS-1:0] start_scale(
		input logic [QP_BITS-1:0]    qp,
		input logic [DEPTH_BITS-1:0] p
	);
		logic [6:0]        u;
		logic [12:0]       recip;
		logic [3:0]        qq;
		logic [6:0]        rem;
		logic [32:0]       m;
		logic signed [7:0] s;
		logic [5:0]        n;
		logic [33:0]       rsum;
		logic [33:0]       v;
		// u = qp + 2 = 6*(q+1) + r; for u up to 65, u*43/256 is exactly u/6.
		u     = qp + 7'd2;
		recip = 13'(u) * 13'd43;
		qq    = recip[11:8];
		rem   = u - 7'(qq) * 7'd6;
		m     = root_sixth(rem[2:0]);
		s     = $signed({3'b000, p}) + $signed({4'b0000, qq}) -
			8'sd49 + 8'(SCALE_FRAC_BITS);
		n     = 6'(-s);
		rsum  = {1'b0, m} + (34'd1 << (n - 6'd1));
		v     = rsum >> n;
		if (qp[QP_BITS-1]) begin
			start_scale = '0;
		end else if (!s[7]) begin
			// The mantissa is at least one, so any left shift saturates.
			start_scale = '1;
		end else if (n >= 6'd40) begin
			start_scale = '0;
		end else if (v > 34'({SCALE_BITS{1'b1}})) begin
			start_scale = '1;
		end else begin
			start_scale = v[SCALE_BITS-1:0];
		end
	endfunction

	back_state_t                     state_q;
	back_state_t                     state_d;
	item_t                           item_q;
	logic [VERTEX_BITS-1:0]          counter_q;
	logic [LEVEL_BITS-1:0]           level_q;
	logic [SCALE_BITS-1:0]           scale_q [NUM_COMP];
	logic [FPROD_W-1:0]              fprod_q [NUM_COMP];
	logic signed [MPROD_W-1:0]       mprod_q [NUM_COMP];
	logic signed [DISP_BITS-1:0]     disp_q  [NUM_COMP];
	logic [15:0]                     vnum_q;
	logic [1:0]                      lnum_q;
	logic                            beyond_q;
	logic                            valid_q;

	logic [LEVEL_BITS-1:0]           level_cap;
	logic [END_BITS-1:0]             cur_end;
	logic                            step_hit;
	logic                            beyond;
	logic                            out_free;
	logic [SCALE_BITS-1:0]           stepped [NUM_COMP];
	logic signed [DISP_BITS-1:0]     result  [NUM_COMP];

	// Level limit and the end of the level the counter sits in.
	always_comb begin
		level_cap = (cfg.level_count > LEVEL_BITS'(LEVEL_CAP)) ?
			LEVEL_BITS'(LEVEL_CAP) : cfg.level_count;
		cur_end   = cfg.level_ends[level_q[SLOT_BITS-1:0]];
		step_hit  = (level_q < level_cap) && (32'(counter_q) >= 32'(cur_end));
		beyond    = (level_q >= level_cap);
		out_free  = !valid_q || !disp_stall;
	end

	// Level step rounding, and the final rounding of each displacement.
	always_comb begin
		for (int k = 0; k < NUM_COMP; k++) begin
			logic [FPROD_W:0]          rsum;
			logic [FPROD_W-FACTOR_FRAC_BITS:0] shifted;
			logic signed [MPROD_W-1:0] rnd;
			logic signed [MPROD_W-1:0] scaled;
			rsum    = {1'b0, fprod_q[k]} + (FPROD_W'(1) << (FACTOR_FRAC_BITS - 1));
			shifted = rsum[FPROD_W:FACTOR_FRAC_BITS];
			stepped[k] = (|shifted[FPROD_W-FACTOR_FRAC_BITS:SCALE_BITS]) ?
				'1 : shifted[SCALE_BITS-1:0];
			// The product stays far inside the output range, so no clamp is needed.
			rnd    = mprod_q[k] + (MPROD_W'(1) <<< (SHIFT - 1));
			scaled = rnd >>> SHIFT;
			if (beyond) begin
				result[k] = {{(DISP_BITS - DIFF_BITS - OUT_FRAC_BITS){item_q.diff[k][DIFF_BITS-1]}},
					item_q.diff[k], {OUT_FRAC_BITS{1'b0}}};
			end else begin
				result[k] = scaled[DISP_BITS-1:0];
			end
		end
	end

	// Next state and queue pop.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = q_data.frame_start ? BK_LOAD : BK_WALK;
				end
			end
			BK_LOAD: begin
				state_d = BK_WALK;
			end
			BK_WALK: begin
				state_d = step_hit ? BK_STEP : BK_MUL;
			end
			BK_STEP: begin
				state_d = BK_WALK;
			end
			BK_MUL: begin
				state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// State, counter, level, scales and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			counter_q <= '0;
			level_q   <= '0;
			valid_q   <= 1'b0;
			for (int k = 0; k < NUM_COMP; k++) begin
				scale_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			// The output holds its transfer until the receiver takes it.
			if (state_q == BK_DONE && out_free) begin
				valid_q <= 1'b1;
			end else if (valid_q && !disp_stall) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				BK_LOAD: begin
					counter_q <= '0;
					level_q   <= '0;
					for (int k = 0; k < NUM_COMP; k++) begin
						scale_q[k] <= start_scale(cfg.qp[k], cfg.pos_depth);
					end
				end
				BK_STEP: begin
					level_q <= level_q + LEVEL_BITS'(1);
					for (int k = 0; k < NUM_COMP; k++) begin
						scale_q[k] <= stepped[k];
					end
				end
				BK_DONE: begin
					if (out_free) begin
						counter_q <= counter_q + VERTEX_BITS'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: popped item, products and the output transfer.
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_data;
		end
		for (int k = 0; k < NUM_COMP; k++) begin
			fprod_q[k] <= scale_q[k] * cfg.level_factors[k];
			mprod_q[k] <= $signed(item_q.diff[k]) * $signed({1'b0, scale_q[k]});
		end
		if (state_q == BK_DONE && out_free) begin
			for (int k = 0; k < NUM_COMP; k++) begin
				disp_q[k] <= result[k];
			end
			vnum_q   <= 16'(counter_q);
			lnum_q   <= beyond ? 2'd0 : level_q[1:0];
			beyond_q <= beyond;
		end
	end

	assign disp_valid    = valid_q;
	assign disp_a        = disp_q[0];
	assign disp_b        = disp_q[1];
	assign disp_c        = disp_q[2];
	assign vertex_number = vnum_q;
	assign level_number  = lnum_q;
	assign beyond_levels = beyond_q;

	// A level step advances the level by exactly one.
	`ASSERT_NEXT(a_step_advances, state_q == BK_STEP, level_q == $past(level_q) + 3'd1, "level step did not advance the level")
	// A frame start restarts the vertex count and the level.
	`ASSERT_NEXT(a_frame_restart, state_q == BK_LOAD, counter_q == '0 && level_q == '0, "frame start did not restart count and level")
	// The level never runs past the number of level end slots.
	`ASSERT_ALWAYS(a_level_bound, level_q <= LEVEL_BITS'(LEVEL_CAP), "level ran past the last slot")

endmodule

@@ design/lod_displacement_dequantizer.sv @@
//  channel   handshake                    payload
//  sample    sample_valid / sample_stall  sample_a, sample_b, sample_c, frame_start
//  disp      disp_valid / disp_stall      disp_a/b/c, vertex_number, level_number, beyond_levels
//  config    APB psel/penable/pwrite      paddr[5:3] selects a 64-bit register
//
//  A vertex passes the back-end sequencer in its pop, level check, multiply and output
//  steps, with a scale load first on a frame start and a level step and fresh check per level end crossed.
//  The sequencer, with two multipliers per component, sets the rate; a two-entry queue
//  lets the sample side keep transferring while the sequencer or the output is busy.
//  Reset clears the queue, the vertex counter, the level and the scales to zero.
//  A stalled output holds its transfer; the sequencer waits in its output step.
module lod_displacement_dequantizer
	import ldq_pkg::*;
#(
	parameter int VERTEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [5:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic [SAMPLE_BITS-1:0]      sample_a,
	input  logic [SAMPLE_BITS-1:0]      sample_b,
	input  logic [SAMPLE_BITS-1:0]      sample_c,
	input  logic                        frame_start,
	output logic                        disp_valid,
	input  logic                        disp_stall,
	output logic signed [DISP_BITS-1:0] disp_a,
	output logic signed [DISP_BITS-1:0] disp_b,
	output logic signed [DISP_BITS-1:0] disp_c,
	output logic [15:0]                 vertex_number,
	output logic [1:0]                  level_number,
	output logic                        beyond_levels
);

	cfg_t                     cfg_q;
	reg_idx_t                 reg_idx;
	logic                     cfg_write;
	logic                     push;
	logic                     pop;
	logic                     q_full;
	logic                     q_empty;
	item_t                    front_item;
	logic [$bits(item_t)-1:0] q_rd_data;

	assign reg_idx   = reg_idx_t'(paddr[5:3]);
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_depth     <= DEPTH_BITS'(12);
			cfg_q.sample_depth  <= DEPTH_BITS'(10);
			cfg_q.qp            <= {NUM_COMP{QP_BITS'(16)}};
			cfg_q.level_factors <= '0;
			cfg_q.level_ends    <= '0;
			cfg_q.level_count   <= LEVEL_BITS'(1);
		end else if (cfg_write) begin
			case (reg_idx)
				REG_POS_DEPTH:     cfg_q.pos_depth     <= pwdata[DEPTH_BITS-1:0];
				REG_SAMPLE_DEPTH:  cfg_q.sample_depth  <= pwdata[DEPTH_BITS-1:0];
				REG_QP_FIRST:      cfg_q.qp[0]         <= pwdata[QP_BITS-1:0];
				REG_QP_SECOND:     cfg_q.qp[1]         <= pwdata[QP_BITS-1:0];
				REG_QP_THIRD:      cfg_q.qp[2]         <= pwdata[QP_BITS-1:0];
				REG_LEVEL_FACTORS: cfg_q.level_factors <= pwdata[NUM_COMP*FACTOR_BITS-1:0];
				REG_LEVEL_ENDS:    cfg_q.level_ends    <= pwdata[END_SLOTS*END_BITS-1:0];
				REG_LEVEL_COUNT:   cfg_q.level_count   <= pwdata[LEVEL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_POS_DEPTH:     prdata = 64'(cfg_q.pos_depth);
			REG_SAMPLE_DEPTH:  prdata = 64'(cfg_q.sample_depth);
			REG_QP_FIRST:      prdata = 64'(cfg_q.qp[0]);
			REG_QP_SECOND:     prdata = 64'(cfg_q.qp[1]);
			REG_QP_THIRD:      prdata = 64'(cfg_q.qp[2]);
			REG_LEVEL_FACTORS: prdata = 64'(cfg_q.level_factors);
			REG_LEVEL_ENDS:    prdata = 64'(cfg_q.level_ends);
			REG_LEVEL_COUNT:   prdata = 64'(cfg_q.level_count);
			default:           prdata = '0;
		endcase
	end

	// Front end: offset removal and queue push.
	ldq_front u_front (
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_a     (sample_a),
		.sample_b     (sample_b),
		.sample_c     (sample_c),
		.frame_start  (frame_start),
		.sample_depth (cfg_q.sample_depth),
		.q_full       (q_full),
		.push         (push),
		.item         (front_item)
	);

	// Queue between the two halves.
	ldq_queue #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_item),
		.pop     (pop),
		.rd_data (q_rd_data),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Back end: scales, level steps and output transfer.
	ldq_back #(
		.VERTEX_BITS (VERTEX_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_data        (item_t'(q_rd_data)),
		.pop           (pop),
		.disp_valid    (disp_valid),
		.disp_stall    (disp_stall),
		.disp_a        (disp_a),
		.disp_b        (disp_b),
		.disp_c        (disp_c),
		.vertex_number (vertex_number),
		.level_number  (level_number),
		.beyond_levels (beyond_levels)
	);

endmodule
